@@ design/tupa_pkg.sv @@
// Shared types, field widths and codes of the typed unit pool allocator.
package tupa_pkg;

    // Default sizing
    localparam int NUM_TYPES_DEF      = 3;
    localparam int UNITS_PER_TYPE_DEF = 16;

    // Field widths fixed by the request and result formats
    localparam int MODE_W    = 1;
    localparam int TYPE_W    = 2;
    localparam int INDEX_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int FREE_W    = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration registers: register i holds the unit count of type i
    localparam int NUM_CFG_REGS = 3;
    localparam logic [CFG_W-1:0] UNITS_RESET = 5'd16;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_TYPE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COUNT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take_req;
        logic exec;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

@@ design/tupa_if.sv @@
// Request, result and configuration channel interfaces.
interface tupa_req_if;
    import tupa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [TYPE_W-1:0]    resource_type;
    logic [INDEX_W-1:0]   unit_index;

    modport source (output valid, output mode, output resource_type, output unit_index,
                    input ready);
    modport sink   (input valid, input mode, input resource_type, input unit_index,
                    output ready);
endinterface

interface tupa_rsp_if;
    import tupa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [STATUS_W-1:0]  status;
    logic [INDEX_W-1:0]   granted_index;
    logic [FREE_W-1:0]    units_free;

    modport source (output valid, output ok, output status, output granted_index,
                    output units_free, input ready);
    modport sink   (input valid, input ok, input status, input granted_index,
                    input units_free, output ready);
endinterface

interface tupa_cfg_if;
    import tupa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/tupa_ctrl.sv @@
// Controller state machine of the typed unit pool allocator.
module tupa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  tupa_pkg::dp_stat_t  stat,
    output tupa_pkg::ctrl_cmd_t cmd
);
    import tupa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance: accept, update bitmap, count and hand off result
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take_req = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_COUNT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ design/tupa_dp.sv @@
// Datapath: unit counts, allocation bitmaps, first-fit search, free count, result register.
module tupa_dp #(
    parameter int NUM_TYPES      = tupa_pkg::NUM_TYPES_DEF,
    parameter int UNITS_PER_TYPE = tupa_pkg::UNITS_PER_TYPE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tupa_pkg::ctrl_cmd_t             cmd,
    output tupa_pkg::dp_stat_t              stat,
    // request
    input  logic                            req_valid,
    input  logic [tupa_pkg::MODE_W-1:0]     req_mode,
    input  logic [tupa_pkg::TYPE_W-1:0]     req_type,
    input  logic [tupa_pkg::INDEX_W-1:0]    req_index,
    // configuration
    input  logic                            cfg_valid,
    input  logic [tupa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tupa_pkg::CFG_W-1:0]      cfg_data,
    // result
    input  logic                            rsp_ready,
    output logic                            rsp_valid,
    output logic                            rsp_ok,
    output logic [tupa_pkg::STATUS_W-1:0]   rsp_status,
    output logic [tupa_pkg::INDEX_W-1:0]    rsp_granted_index,
    output logic [tupa_pkg::FREE_W-1:0]     rsp_units_free
);
    import tupa_pkg::*;

    localparam int CNT_W = $clog2(UNITS_PER_TYPE + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int IDX_W = (UNITS_PER_TYPE > 1) ? $clog2(UNITS_PER_TYPE) : 1;

    // Operand registers
    logic [MODE_W-1:0]         mode_reg;
    logic [TYPE_W-1:0]         type_reg;
    logic [INDEX_W-1:0]        uidx_reg;

    // Configuration and allocation state
    logic [CFG_W-1:0]          units_reg [NUM_TYPES];
    logic [UNITS_PER_TYPE-1:0] map_reg   [NUM_TYPES];

    // Intermediate decision
    logic                      dec_ok_reg;
    logic [STATUS_W-1:0]       dec_status_reg;
    logic [IDX_W-1:0]          dec_grant_reg;

    // Result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_ok_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [INDEX_W-1:0]        out_grant_reg;
    logic [FREE_W-1:0]         out_free_reg;

    // Combinational
    logic                      type_ok;
    logic [CFG_W-1:0]          cfg_sel;
    logic [UNITS_PER_TYPE-1:0] map_sel;
    logic [CNT_W-1:0]          n_sel;
    logic [UNITS_PER_TYPE-1:0] mask;
    logic [UNITS_PER_TYPE-1:0] cand;
    logic [UNITS_PER_TYPE-1:0] grant_onehot;
    logic [UNITS_PER_TYPE-1:0] clr_onehot;
    logic [UNITS_PER_TYPE-1:0] shifted;
    logic                      found;
    logic [IDX_W-1:0]          grant_idx;
    logic                      idx_hit;
    logic                      dec_ok;
    logic [STATUS_W-1:0]       dec_status;
    logic [CNT_W-1:0]          free_cnt;
    logic [FREE_W-1:0]         free_out;

    // Select the addressed type
    always_comb
    begin
        type_ok = (int'(type_reg) < NUM_TYPES);
        cfg_sel = '0;
        map_sel = '0;
        for (int t = 0; t < NUM_TYPES; t++)
        begin
            if (int'(type_reg) == t)
            begin
                cfg_sel = units_reg[t];
                map_sel = map_reg[t];
            end
        end
    end

    // Saturate the unit count and build the in-range mask
    always_comb
    begin
        if (CMP_W'(cfg_sel) > CMP_W'(UNITS_PER_TYPE))
        begin
            n_sel = CNT_W'(UNITS_PER_TYPE);
        end
        else
        begin
            n_sel = CNT_W'(cfg_sel);
        end
        for (int i = 0; i < UNITS_PER_TYPE; i++)
        begin
            mask[i] = (CMP_W'(i) < CMP_W'(n_sel));
        end
    end

    // Find the lowest free unit
    always_comb
    begin
        cand         = ~map_sel & mask;
        found        = |cand;
        grant_onehot = cand & (~cand + UNITS_PER_TYPE'(1));
        grant_idx    = '0;
        for (int i = UNITS_PER_TYPE - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                grant_idx = IDX_W'(i);
            end
        end
    end

    // Check the unit to free
    always_comb
    begin
        shifted    = map_sel >> uidx_reg;
        idx_hit    = (CMP_W'(uidx_reg) < CMP_W'(n_sel)) && shifted[0];
        clr_onehot = UNITS_PER_TYPE'(1) << uidx_reg;
    end

    // Decide status
    always_comb
    begin
        dec_ok     = 1'b0;
        dec_status = STAT_OK;
        if (!type_ok)
        begin
            dec_status = STAT_BAD_TYPE;
        end
        else if (mode_reg == MODE_ALLOC)
        begin
            dec_ok     = found;
            dec_status = found ? STAT_OK : STAT_NONE_FREE;
        end
        else
        begin
            dec_ok     = idx_hit;
            dec_status = idx_hit ? STAT_OK : STAT_BAD_INDEX;
        end
    end

    // Count free units of the updated bitmap
    always_comb
    begin
        free_cnt = '0;
        for (int i = 0; i < UNITS_PER_TYPE; i++)
        begin
            free_cnt = free_cnt + CNT_W'(cand[i]);
        end
        if (dec_status_reg == STAT_BAD_TYPE || dec_status_reg == STAT_NONE_FREE)
        begin
            free_out = '0;
        end
        else
        begin
            free_out = FREE_W'(free_cnt);
        end
    end

    // Latch the request operands
    always_ff @(posedge clk)
    begin
        if (cmd.take_req && req_valid)
        begin
            mode_reg <= req_mode;
            type_reg <= req_type;
            uidx_reg <= req_index;
        end
    end

    // Write unit counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                units_reg[t] <= UNITS_RESET;
            end
        end
        else if (cfg_valid && int'(cfg_index) < NUM_CFG_REGS)
        begin
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                if (int'(cfg_index) == t)
                begin
                    units_reg[t] <= cfg_data;
                end
            end
        end
    end

    // Set or clear a bit of the addressed bitmap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                map_reg[t] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                if (int'(type_reg) == t)
                begin
                    if (mode_reg == MODE_ALLOC && found)
                    begin
                        map_reg[t] <= map_reg[t] | grant_onehot;
                    end
                    else if (mode_reg == MODE_FREE && idx_hit)
                    begin
                        map_reg[t] <= map_reg[t] & ~clr_onehot;
                    end
                end
            end
        end
    end

    // Hold the decision until the count is done
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            dec_ok_reg     <= dec_ok;
            dec_status_reg <= dec_status;
            dec_grant_reg  <= (mode_reg == MODE_ALLOC && dec_ok) ? grant_idx : '0;
        end
    end

    // Result valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_ok_reg     <= dec_ok_reg;
            out_status_reg <= dec_status_reg;
            out_grant_reg  <= INDEX_W'(dec_grant_reg);
            out_free_reg   <= free_out;
        end
    end

    assign stat.out_free      = !out_valid_reg || rsp_ready;
    assign rsp_valid          = out_valid_reg;
    assign rsp_ok             = out_ok_reg;
    assign rsp_status         = out_status_reg;
    assign rsp_granted_index  = out_grant_reg;
    assign rsp_units_free     = out_free_reg;

endmodule

@@ design/typed_unit_pool_allocator.sv @@
// Top level of the typed unit pool allocator: controller, datapath and channel hookup.
//
//  channel | dir | payload                                       | handshake
//  --------+-----+-----------------------------------------------+------------
//  req     | in  | mode, resource_type, unit_index               | valid/ready
//  rsp     | out | ok, status, granted_index, units_free         | valid/ready
//  cfg     | in  | index (unit-count register), data             | valid/ready
//
// Each request passes through three steps: accept, bitmap search and update, free count.
// The free-count popcount runs on the updated bitmap in its own cycle after the update.
// A finished result sits in the output register, so the next request is accepted
// while the previous result waits; a stall on rsp holds the count stage.
// Reset clears all bitmaps and sets every unit count to 16; cfg is always ready.
module typed_unit_pool_allocator #(
    parameter int NUM_TYPES      = tupa_pkg::NUM_TYPES_DEF,
    parameter int UNITS_PER_TYPE = tupa_pkg::UNITS_PER_TYPE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tupa_req_if.sink    req,
    tupa_rsp_if.source  rsp,
    tupa_cfg_if.sink    cfg
);
    import tupa_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequence each request
    tupa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Bitmaps, counts and result
    tupa_dp #(
        .NUM_TYPES      (NUM_TYPES),
        .UNITS_PER_TYPE (UNITS_PER_TYPE)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .req_valid         (req.valid),
        .req_mode          (req.mode),
        .req_type          (req.resource_type),
        .req_index         (req.unit_index),
        .cfg_valid         (cfg.valid),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .rsp_ok            (rsp.ok),
        .rsp_status        (rsp.status),
        .rsp_granted_index (rsp.granted_index),
        .rsp_units_free    (rsp.units_free)
    );

    assign req.ready = cmd.take_req;
    assign cfg.ready = 1'b1;

endmodule

@@ design/tupa_checker.sv @@
// Port-level checker for the typed unit pool allocator, bound to the top level.
module tupa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic                           rsp_ok,
    input logic [tupa_pkg::STATUS_W-1:0]  rsp_status,
    input logic [tupa_pkg::INDEX_W-1:0]   rsp_granted_index,
    input logic [tupa_pkg::FREE_W-1:0]    rsp_units_free
);
    import tupa_pkg::*;

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_ok))
        else $error("result changed while stalled");

    // One request in flight: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // Success flag agrees with status
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_ok == (rsp_status == STAT_OK)))
        else $error("ok flag disagrees with status");

    // Failed operation grants nothing
    a_fail_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_granted_index == '0)
        else $error("granted index on a failed operation");

    // Bad type or empty pool reports no free units
    a_fail_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STAT_BAD_TYPE || rsp_status == STAT_NONE_FREE)
        |-> rsp_units_free == '0)
        else $error("free count on bad type or empty pool");

endmodule

bind typed_unit_pool_allocator tupa_checker u_tupa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_ok            (rsp.ok),
    .rsp_status        (rsp.status),
    .rsp_granted_index (rsp.granted_index),
    .rsp_units_free    (rsp.units_free)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the typed unit pool allocator.
module testbench;
    import tupa_pkg::*;

    // Resource type codes
    localparam logic [TYPE_W-1:0] RT_DISK     = 2'd0;
    localparam logic [TYPE_W-1:0] RT_PRINTER  = 2'd1;
    localparam logic [TYPE_W-1:0] RT_KEYBOARD = 2'd2;
    localparam logic [TYPE_W-1:0] RT_INVALID  = 2'd3;

    // Unit-count register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISK_UNITS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRINTER_UNITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEYBOARD_UNITS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE          = 2'd3;

    localparam int PHASE_ITEMS = 260;
    localparam int NUM_PHASES  = 7;

    typedef struct packed {
        logic                ok;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted_index;
        logic [FREE_W-1:0]   units_free;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n;
    logic calm = 1'b0;

    tupa_req_if req_bus ();
    tupa_rsp_if rsp_bus ();
    tupa_cfg_if cfg_bus ();

    // Shadow of the allocator: held units and unit counts per type
    logic [UNITS_PER_TYPE_DEF-1:0] held_map [NUM_TYPES_DEF];
    logic [CFG_W-1:0]              unit_limit [NUM_TYPES_DEF];

    outcome_t pending_outcomes [$];
    int       mismatch_count = 0;

    typed_unit_pool_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    always #5 clk = ~clk;

    // Count a failure, show only the first few
    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // Append a prediction at the tail of the expected-result queue
    task automatic queue_outcome(input outcome_t o);
        pending_outcomes.insert(pending_outcomes.size(), o);
    endtask

    // Usable units of a type: register value saturated to the pool size
    function automatic int pool_size(input int t);
        return (unit_limit[t] > UNITS_PER_TYPE_DEF) ? UNITS_PER_TYPE_DEF : int'(unit_limit[t]);
    endfunction

    // Number of clear bits of the map below the usable count
    function automatic int idle_units(input int t);
        int c;
        int i;
        c = 0;
        for (i = 0; i < pool_size(t); i++)
            if (!held_map[t][i])
                c++;
        return c;
    endfunction

    // Compute the outcome of one request and update the shadow maps
    function automatic outcome_t predict_outcome(input logic [MODE_W-1:0] m,
                                                 input logic [TYPE_W-1:0] rt,
                                                 input logic [INDEX_W-1:0] idx);
        outcome_t r;
        int       n;
        int       slot;
        int       i;
        r = '0;
        r.status = STAT_OK;
        if (rt >= NUM_TYPES_DEF)
        begin
            r.status = STAT_BAD_TYPE;
        end
        else if (m == MODE_ALLOC)
        begin
            n = pool_size(rt);
            slot = -1;
            for (i = 0; i < n; i++)
                if (slot < 0 && !held_map[rt][i])
                    slot = i;
            if (slot >= 0)
            begin
                held_map[rt][slot] = 1'b1;
                r.ok = 1'b1;
                r.granted_index = slot[INDEX_W-1:0];
                r.units_free = FREE_W'(idle_units(rt));
            end
            else
            begin
                r.status = STAT_NONE_FREE;
            end
        end
        else
        begin
            n = pool_size(rt);
            if (int'(idx) >= n || !held_map[rt][idx])
            begin
                r.status = STAT_BAD_INDEX;
            end
            else
            begin
                held_map[rt][idx] = 1'b0;
                r.ok = 1'b1;
            end
            r.units_free = FREE_W'(idle_units(rt));
        end
        return r;
    endfunction

    // Send one request, idling the channel at random first
    task automatic send_op(input logic [MODE_W-1:0] m, input logic [TYPE_W-1:0] rt,
                           input logic [INDEX_W-1:0] idx);
        while (!calm && $urandom_range(99) < 17)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.mode          <= m;
        req_bus.resource_type <= rt;
        req_bus.unit_index    <= idx;
        do
            @(posedge clk);
        while (!req_bus.ready);
        queue_outcome(predict_outcome(m, rt, idx));
    endtask

    // Drop valid and wait until every result is back, then let the pipe settle
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Write one unit-count register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        if (idx < NUM_CFG_REGS && idx < NUM_TYPES_DEF)
            unit_limit[idx] = val;
        @(posedge clk);
    endtask

    // Stall the result channel at random
    always @(posedge clk)
        rsp_bus.ready <= calm || ($urandom_range(99) >= 17);

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        outcome_t seen;
        outcome_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            seen.ok            = rsp_bus.ok;
            seen.status        = rsp_bus.status;
            seen.granted_index = rsp_bus.granted_index;
            seen.units_free    = rsp_bus.units_free;
            if (pending_outcomes.size() == 0)
            begin
                note_failure($sformatf("unexpected result: ok=%0d status=%0d grant=%0d free=%0d",
                                       seen.ok, seen.status, seen.granted_index,
                                       seen.units_free));
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (seen !== want)
                    note_failure($sformatf({"result mismatch: expected ok=%0d status=%0d ",
                                            "grant=%0d free=%0d, got ok=%0d status=%0d ",
                                            "grant=%0d free=%0d"},
                                           want.ok, want.status, want.granted_index,
                                           want.units_free, seen.ok, seen.status,
                                           seen.granted_index, seen.units_free));
            end
        end
    end

    // Rejections: free of an idle unit, unknown type
    task automatic test_rejections();
        send_op(MODE_FREE, RT_DISK, 4'd0);
        send_op(MODE_ALLOC, RT_INVALID, 4'd15);
        send_op(MODE_FREE, RT_INVALID, 4'd15);
        send_op(MODE_FREE, RT_KEYBOARD, 4'd15);
    endtask

    // Grant on every type, release on disk
    task automatic test_grant_release();
        send_op(MODE_ALLOC, RT_DISK, 4'd15);
        send_op(MODE_ALLOC, RT_PRINTER, 4'd0);
        send_op(MODE_ALLOC, RT_KEYBOARD, 4'd9);
        send_op(MODE_FREE, RT_DISK, 4'd0);
        send_op(MODE_ALLOC, RT_DISK, 4'd6);
        send_op(MODE_FREE, RT_DISK, 4'd0);
    endtask

    // Exhaustion, zero count, saturated count and the spare register
    task automatic test_limits();
        drain_results();
        write_reg(REG_DISK_UNITS, 5'd2);
        write_reg(REG_PRINTER_UNITS, 5'd0);
        write_reg(REG_KEYBOARD_UNITS, 5'd31);
        write_reg(REG_SPARE, 5'd5);
        send_op(MODE_ALLOC, RT_DISK, 4'd0);
        send_op(MODE_ALLOC, RT_DISK, 4'd0);
        send_op(MODE_ALLOC, RT_DISK, 4'd0);
        send_op(MODE_ALLOC, RT_PRINTER, 4'd0);
        send_op(MODE_FREE, RT_PRINTER, 4'd0);
        send_op(MODE_FREE, RT_DISK, 4'd2);
        send_op(MODE_FREE, RT_DISK, 4'd15);
        send_op(MODE_ALLOC, RT_KEYBOARD, 4'd0);
    endtask

    // Lower the count under held units, then raise it and release them
    task automatic test_shrink_while_held();
        drain_results();
        write_reg(REG_DISK_UNITS, 5'd1);
        send_op(MODE_FREE, RT_DISK, 4'd1);
        send_op(MODE_ALLOC, RT_DISK, 4'd0);
        drain_results();
        write_reg(REG_DISK_UNITS, 5'd16);
        send_op(MODE_FREE, RT_DISK, 4'd1);
        send_op(MODE_FREE, RT_DISK, 4'd0);
    endtask

    // Random traffic across several unit-count settings
    task automatic test_random_traffic();
        logic [CFG_W-1:0]   plan [4][3];
        logic [CFG_W-1:0]   counts [3];
        logic [TYPE_W-1:0]  rt;
        logic [INDEX_W-1:0] idx;
        int                 held [$];
        int                 phase;
        int                 k;
        int                 j;
        int                 roll;
        plan = '{'{5'd16, 5'd16, 5'd16}, '{5'd0, 5'd1, 5'd31},
                 '{5'd2, 5'd16, 5'd5}, '{5'd31, 5'd0, 5'd16}};
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();
            for (j = 0; j < 3; j++)
                counts[j] = (phase < 4) ? plan[phase][j] : CFG_W'($urandom_range(0, 31));
            write_reg(REG_DISK_UNITS, counts[0]);
            write_reg(REG_PRINTER_UNITS, counts[1]);
            write_reg(REG_KEYBOARD_UNITS, counts[2]);
            if ($urandom_range(1) == 1)
                write_reg(REG_SPARE, CFG_W'($urandom()));
            calm = (phase == 2);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(99);
                rt = TYPE_W'($urandom_range(0, NUM_TYPES_DEF - 1));
                idx = INDEX_W'($urandom());
                if (roll < 5)
                begin
                    send_op(MODE_W'($urandom()), RT_INVALID, idx);
                end
                else if (roll < 50)
                begin
                    send_op(MODE_ALLOC, rt, idx);
                end
                else if (roll < 88)
                begin
                    // release a unit that is really held, else grant one
                    held.delete();
                    for (j = 0; j < pool_size(rt); j++)
                        if (held_map[rt][j])
                            held.insert(held.size(), j);
                    if (held.size() != 0)
                        send_op(MODE_FREE, rt,
                                INDEX_W'(held[$urandom_range(held.size() - 1)]));
                    else
                        send_op(MODE_ALLOC, rt, idx);
                end
                else
                begin
                    send_op(MODE_FREE, rt, idx);
                end
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        int t;
        for (t = 0; t < NUM_TYPES_DEF; t++)
        begin
            held_map[t]   = '0;
            unit_limit[t] = UNITS_RESET;
        end
        rst_n                 <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.mode          <= MODE_ALLOC;
        req_bus.resource_type <= RT_DISK;
        req_bus.unit_index    <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= REG_DISK_UNITS;
        cfg_bus.data          <= UNITS_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rejections();
        test_grant_release();
        test_limits();
        test_shrink_while_held();
        test_random_traffic();

        drain_results();
        if (pending_outcomes.size() != 0)
            note_failure("results still outstanding at end of run");
        if (mismatch_count == 0)
            $display("** typed_unit_pool_allocator: PASSED **");
        else
            $display("** typed_unit_pool_allocator: FAILED **");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #3000000;
        $display("** typed_unit_pool_allocator: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
design/tupa_pkg.sv
design/tupa_if.sv
design/tupa_ctrl.sv
design/tupa_dp.sv
design/typed_unit_pool_allocator.sv
design/tupa_checker.sv
tb/testbench.sv
